// ===== rtl/top_n_score_keeper_assert.svh =====
// Assertion helpers for the score keeper.
`ifndef TOP_N_SCORE_KEEPER_ASSERT_SVH
`define TOP_N_SCORE_KEEPER_ASSERT_SVH

// Concurrent check sampled on the rising clock, off while reset is low.
`define NSK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define NSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/nsk_pkg.sv =====
`timescale 1ns / 1ps
package nsk_pkg;

  typedef logic signed [31:0] score_t;
  typedef logic        [15:0] player_t;
  typedef logic        [4:0]  index_t;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam score_t SCORE_MIN = 32'sh8000_0000;
  localparam score_t SCORE_MAX = 32'sh7FFF_FFFF;

  // Compare results that a cell hands to the insertion control.
  typedef struct packed {
    logic ahead;   // kept entry strictly better than the new score
    logic beaten;  // new score strictly better than the kept entry
  } cell_flags_t;

  // a strictly better than b in the given mode
  function automatic logic better(input logic higher_is_better, input score_t a,
                                  input score_t b);
    better = higher_is_better ? (a > b) : (b > a);
  endfunction

  function automatic score_t worst(input logic higher_is_better);
    worst = higher_is_better ? SCORE_MIN : SCORE_MAX;
  endfunction

endpackage

// ===== rtl/nsk_req_if.sv =====
`timescale 1ns / 1ps
interface nsk_req_if;
  logic                valid;
  logic                ready;
  logic [1:0]          operation;
  nsk_pkg::player_t    player_id;
  nsk_pkg::score_t     score;
  nsk_pkg::index_t     entry_index;

  modport source (output valid, operation, player_id, score, entry_index, input ready);
  modport sink   (input valid, operation, player_id, score, entry_index, output ready);
endinterface

// ===== rtl/nsk_rsp_if.sv =====
`timescale 1ns / 1ps
interface nsk_rsp_if;
  logic                valid;
  logic                ready;
  logic                accepted;
  nsk_pkg::player_t    entry_player;
  nsk_pkg::score_t     entry_score;

  modport source (output valid, accepted, entry_player, entry_score, input ready);
  modport sink   (input valid, accepted, entry_player, entry_score, output ready);
endinterface

// ===== rtl/nsk_cell.sv =====
`timescale 1ns / 1ps
module nsk_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mode_i,
  input  logic                  clear_i,
  input  logic                  shift_i,
  input  logic                  load_i,
  input  nsk_pkg::player_t      new_player_i,
  input  nsk_pkg::score_t       new_score_i,
  input  nsk_pkg::player_t      upper_player_i,
  input  nsk_pkg::score_t       upper_score_i,
  output nsk_pkg::player_t      player_o,
  output nsk_pkg::score_t       score_o,
  output nsk_pkg::cell_flags_t  flags_o
);

  nsk_pkg::player_t player_q;
  nsk_pkg::score_t  score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_q <= '0;
      score_q  <= nsk_pkg::SCORE_MIN;
    end else if (clear_i) begin
      player_q <= '0;
      score_q  <= nsk_pkg::worst(mode_i);
    end else if (shift_i) begin
      // entry above moves down one place
      player_q <= upper_player_i;
      score_q  <= upper_score_i;
    end else if (load_i) begin
      player_q <= new_player_i;
      score_q  <= new_score_i;
    end
  end

  assign player_o       = player_q;
  assign score_o        = score_q;
  assign flags_o.ahead  = nsk_pkg::better(mode_i, score_q, new_score_i);
  assign flags_o.beaten = nsk_pkg::better(mode_i, new_score_i, score_q);

endmodule

// ===== rtl/top_n_score_keeper.sv =====
`timescale 1ns / 1ps
// Keeps the LIST_ENTRIES best (player, score) pairs, worst entry at index 0.
// Requests arrive on req (valid/ready); each beat carries an operation:
// add, clear or read. Every request beat yields exactly one response beat on
// rsp: accepted for an add, entry_player/entry_score for a read, zeros else.
// The mode bit higher_is_better is written through higher_is_better_we_i and
// should only change while no request is outstanding; clear the list after.
// Throughput: one request per cycle while rsp is not stalled. Each cell
// compares its entry against the incoming score in parallel; the insertion
// point is found from those flags and every cell updates (hold, take the
// entry above, load the new pair, or clear) at the accept edge. The response
// is captured in the output register at the accept edge.
// When rsp is stalled the output register holds its beat and req.ready stays
// low until it drains; req.ready is high whenever the register is empty or
// being taken in the same cycle.
// Reset: mode is higher-is-better, every entry holds the lowest score with
// player 0, and the output register is empty.
module top_n_score_keeper #(
  parameter int LIST_ENTRIES = 20
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       higher_is_better_we_i,
  input  logic       higher_is_better_i,
  nsk_req_if.sink    req,
  nsk_rsp_if.source  rsp
);

  logic mode_q;
  logic in_acc;
  logic is_add;
  logic is_clear;
  logic is_read;
  logic insert;

  nsk_pkg::player_t     cell_player [LIST_ENTRIES];
  nsk_pkg::score_t      cell_score  [LIST_ENTRIES];
  nsk_pkg::cell_flags_t cell_flags  [LIST_ENTRIES];

  logic [LIST_ENTRIES-1:0] stop_w;
  logic [LIST_ENTRIES-1:0] run_w;
  logic [LIST_ENTRIES-1:0] shift_w;
  logic [LIST_ENTRIES-1:0] load_w;

  logic             out_valid_q, out_valid_d;
  logic             acc_q, acc_d;
  nsk_pkg::player_t rd_player_q, rd_player_d;
  nsk_pkg::score_t  rd_score_q, rd_score_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (higher_is_better_we_i) begin
      mode_q <= higher_is_better_i;
    end
  end

  assign req.ready = !out_valid_q || rsp.ready;
  assign in_acc    = req.valid && req.ready;
  assign is_add    = in_acc && (req.operation == nsk_pkg::OP_ADD);
  assign is_clear  = in_acc && (req.operation == nsk_pkg::OP_CLEAR);
  assign is_read   = req.operation == nsk_pkg::OP_READ;
  assign insert    = is_add && cell_flags[0].beaten;

  // A cell stops the shift when its entry is strictly better than the new
  // score; entry 0 is always dropped so it never stops.
  genvar j;
  generate
    for (j = 0; j < LIST_ENTRIES; j++) begin : g_cell
      if (j == 0) begin : g_stop0
        assign stop_w[j] = 1'b0;
      end else begin : g_stopn
        assign stop_w[j] = cell_flags[j].ahead;
      end

      assign run_w[j] = insert && !(|stop_w[j:0]);

      if (j < LIST_ENTRIES - 1) begin : g_mid
        assign shift_w[j] = run_w[j+1];
      end else begin : g_top
        assign shift_w[j] = 1'b0;
      end
      assign load_w[j] = run_w[j] && !shift_w[j];

      nsk_cell u_cell (
        .clk_i          (clk_i),
        .rst_ni         (rst_ni),
        .mode_i         (mode_q),
        .clear_i        (is_clear),
        .shift_i        (shift_w[j]),
        .load_i         (load_w[j]),
        .new_player_i   (req.player_id),
        .new_score_i    (req.score),
        .upper_player_i (cell_player[(j < LIST_ENTRIES - 1) ? j + 1 : j]),
        .upper_score_i  (cell_score[(j < LIST_ENTRIES - 1) ? j + 1 : j]),
        .player_o       (cell_player[j]),
        .score_o        (cell_score[j]),
        .flags_o        (cell_flags[j])
      );
    end
  endgenerate

  always_comb begin
    rd_player_d = '0;
    rd_score_d  = '0;
    for (int k = 0; k < LIST_ENTRIES; k++) begin
      if (is_read && (int'(req.entry_index) == k)) begin
        rd_player_d = cell_player[k];
        rd_score_d  = cell_score[k];
      end
    end
  end

  assign acc_d = insert;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q       <= acc_d;
      rd_player_q <= rd_player_d;
      rd_score_q  <= rd_score_d;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.accepted     = acc_q;
  assign rsp.entry_player = rd_player_q;
  assign rsp.entry_score  = rd_score_q;

`include "top_n_score_keeper_assert.svh"

  `NSK_ASSERT(a_rise_after_req, clk_i, rst_ni, $rose(out_valid_q) |-> $past(in_acc), "response beat without a request beat")
  `NSK_ASSERT_NEXT(a_acc_only_add, clk_i, rst_ni, in_acc && (req.operation != nsk_pkg::OP_ADD), !rsp.accepted, "accepted set for a non-add operation")
  `NSK_ASSERT_NEXT(a_clear_worst, clk_i, rst_ni, is_clear, cell_score[0] == nsk_pkg::worst($past(mode_q)), "clear did not load the worst score")
  `NSK_ASSERT(a_single_insert, clk_i, rst_ni, $countones(load_w) <= 1, "new pair loaded into more than one cell")

endmodule
